@@ hw/rtl/kts_pkg.sv @@
package kts_pkg;

    // Field widths of the item and result channels
    localparam int KEY_W  = 32;
    localparam int IDX_W  = 8;
    localparam int POS_W  = 8;
    localparam int MODE_W = 2;
    localparam int CNT_W  = 9;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes, taken from paddr[2]
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    // Search modes; the unused code runs as linear
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ORDERED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BINARY  = 2'd2;

    // Item actions
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Flip the sign bit to turn signed order into unsigned order
    localparam logic [KEY_W-1:0] KEY_BIAS = 32'h8000_0000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  count;
    } t_cfg;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/kts_if.sv @@
interface kts_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [kts_pkg::IDX_W-1:0]           entry_index;
    logic signed [kts_pkg::KEY_W-1:0]    key;

    modport source (output valid, action, entry_index, key, input ready);
    modport sink   (input valid, action, entry_index, key, output ready);
endinterface

interface kts_out_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [kts_pkg::POS_W-1:0]           position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

@@ hw/rtl/kts_cmp.sv @@
module kts_cmp (
    input  logic [kts_pkg::KEY_W-1:0] i_target,
    input  logic [kts_pkg::KEY_W-1:0] i_entry,
    output kts_pkg::t_cmp             o_cmp
);

    logic [kts_pkg::KEY_W-1:0] w_t;
    logic [kts_pkg::KEY_W-1:0] w_e;

    // Compare signed keys through their biased unsigned form
    assign w_t       = i_target ^ kts_pkg::KEY_BIAS;
    assign w_e       = i_entry ^ kts_pkg::KEY_BIAS;
    assign o_cmp.eq  = (w_t == w_e);
    assign o_cmp.lt  = (w_t < w_e);

endmodule

@@ hw/rtl/kts_mem.sv @@
module kts_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [kts_pkg::KEY_W-1:0] i_wr_data,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [kts_pkg::KEY_W-1:0] o_rd_data
);

    logic [kts_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic [kts_pkg::KEY_W-1:0] r_rd_data;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/kts_cfg.sv @@
module kts_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kts_pkg::PADDR_W-1:0] paddr,
    input  logic [kts_pkg::PDATA_W-1:0] pwdata,
    output logic [kts_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output kts_pkg::t_cfg               o_cfg
);

    logic [kts_pkg::MODE_W-1:0] r_mode;
    logic [kts_pkg::CNT_W-1:0]  r_count;
    logic                       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= kts_pkg::MODE_LINEAR;
            r_count <= '0;
        end else if (w_wr) begin
            case (paddr[2])
                kts_pkg::REG_MODE:  r_mode  <= pwdata[kts_pkg::MODE_W-1:0];
                kts_pkg::REG_COUNT: r_count <= pwdata[kts_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr[2])
            kts_pkg::REG_MODE:  prdata = kts_pkg::PDATA_W'(r_mode);
            kts_pkg::REG_COUNT: prdata = kts_pkg::PDATA_W'(r_count);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.mode  = r_mode;
    assign o_cfg.count = r_count;

endmodule

@@ hw/rtl/kts_seq.sv @@
module kts_seq #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kts_pkg::t_cfg             i_cfg,
    kts_in_if.sink                    i_in,
    kts_out_if.source                 o_out,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic [kts_pkg::KEY_W-1:0] o_wr_data,
    output logic [AW-1:0]             o_rd_addr,
    input  logic [kts_pkg::KEY_W-1:0] i_rd_data
);

    localparam int CW = $clog2(DEPTH + 1);

    kts_pkg::t_state           r_state, n_state;
    logic [kts_pkg::KEY_W-1:0] r_target, n_target;
    logic                      r_bin, n_bin;
    logic                      r_early, n_early;
    logic [CW-1:0]             r_count, n_count;
    logic [AW-1:0]             r_addr, n_addr;
    logic [AW-1:0]             r_lo, n_lo;
    logic [AW-1:0]             r_hi, n_hi;
    logic                      r_hit, n_hit;
    logic                      r_out_valid, n_out_valid;
    logic                      r_found, n_found;
    logic [kts_pkg::POS_W-1:0] r_pos, n_pos;

    kts_pkg::t_cmp             w_cmp;
    logic                      w_accept;
    logic                      w_load;
    logic [CW-1:0]             w_used;
    logic [AW:0]               w_sum;

    // Shared key comparator
    kts_cmp u_cmp (
        .i_target (r_target),
        .i_entry  (i_rd_data),
        .o_cmp    (w_cmp)
    );

    assign i_in.ready = (r_state == kts_pkg::S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = (r_state == kts_pkg::S_DONE) && (!r_out_valid || o_out.ready);

    // Cap the entry count at the depth
    assign w_used = (32'(i_cfg.count) > DEPTH) ? CW'(DEPTH) : CW'(i_cfg.count);

    // Table writes straight from the accepted item
    assign o_wr_en   = w_accept && (i_in.action == kts_pkg::ACT_WRITE)
                       && (32'(i_in.entry_index) < DEPTH);
    assign o_wr_addr = AW'(i_in.entry_index);
    assign o_wr_data = i_in.key;
    assign o_rd_addr = r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kts_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_target <= n_target;
        r_bin    <= n_bin;
        r_early  <= n_early;
        r_count  <= n_count;
        r_addr   <= n_addr;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_hit    <= n_hit;
        r_found  <= n_found;
        r_pos    <= n_pos;
    end

    // Sequencer: each probe passes through a read state and a compare state
    always_comb begin
        n_state     = r_state;
        n_target    = r_target;
        n_bin       = r_bin;
        n_early     = r_early;
        n_count     = r_count;
        n_addr      = r_addr;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && !o_out.ready;
        n_found     = r_found;
        n_pos       = r_pos;
        w_sum       = '0;

        case (r_state)
            kts_pkg::S_IDLE: begin
                if (w_accept && (i_in.action == kts_pkg::ACT_SEARCH)) begin
                    n_target = i_in.key;
                    n_bin    = (i_cfg.mode == kts_pkg::MODE_BINARY);
                    n_early  = (i_cfg.mode == kts_pkg::MODE_ORDERED);
                    n_count  = w_used;
                    n_lo     = '0;
                    n_hi     = AW'(w_used - CW'(1));
                    n_hit    = 1'b0;
                    if (i_cfg.mode == kts_pkg::MODE_BINARY) begin
                        n_addr = AW'((w_used - CW'(1)) >> 1);
                    end else begin
                        n_addr = '0;
                    end
                    // Empty table: answer at once
                    n_state = (w_used == '0) ? kts_pkg::S_DONE : kts_pkg::S_READ;
                end
            end
            kts_pkg::S_READ: begin
                n_state = kts_pkg::S_CMP;
            end
            kts_pkg::S_CMP: begin
                if (w_cmp.eq) begin
                    n_hit   = 1'b1;
                    n_state = kts_pkg::S_DONE;
                end else if (r_bin) begin
                    // Halve the interval, stop when it empties
                    if (w_cmp.lt) begin
                        n_hi = r_addr - AW'(1);
                    end else begin
                        n_lo = r_addr + AW'(1);
                    end
                    w_sum  = {1'b0, n_lo} + {1'b0, n_hi};
                    n_addr = w_sum[AW:1];
                    if ((w_cmp.lt && r_addr == r_lo) || (!w_cmp.lt && r_addr == r_hi)) begin
                        n_state = kts_pkg::S_DONE;
                    end else begin
                        n_state = kts_pkg::S_READ;
                    end
                end else if ((r_early && w_cmp.lt)
                             || (32'(r_addr) + 32'd1 == 32'(r_count))) begin
                    n_state = kts_pkg::S_DONE;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = kts_pkg::S_READ;
                end
            end
            kts_pkg::S_DONE: begin
                // Hand over the result once the output register is free
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_found     = r_hit;
                    n_pos       = r_hit ? kts_pkg::POS_W'(r_addr) : '0;
                    n_state     = kts_pkg::S_IDLE;
                end
            end
            default: n_state = kts_pkg::S_IDLE;
        endcase
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.found    = r_found;
    assign o_out.position = r_pos;

    // Probe address always lies inside the used entries
    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kts_pkg::S_CMP) |-> (32'(r_addr) < 32'(r_count)))
        else $error("probe address beyond used entries");

    // Binary interval is never empty while probing
    a_bin_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kts_pkg::S_CMP && r_bin) |-> (r_lo <= r_addr && r_addr <= r_hi))
        else $error("binary probe outside interval");

    // A new result comes only out of the done state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !$past(o_out.valid && !o_out.ready))
        |-> $past(r_state == kts_pkg::S_DONE))
        else $error("result without finished search");

    // A miss reports position zero
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.position == '0))
        else $error("miss with nonzero position");

endmodule

@@ hw/rtl/key_table_search.sv @@
// Channel  Dir  Payload                         Handshake
// i_in     in   action, entry_index, key        valid/ready
// o_out    out  found, position                 valid/ready
// apb      in   mode @0x0, count @0x4 (32 bit)  psel/penable/pwrite/pready
//
// A write item leaves the block in the idle state, ready for the next item.
// A search goes from idle through a read state and a compare state per probed
// entry to the done state: linear up to count probes, binary about log2(count)+1;
// one read port of the key memory and one comparator make each probe a read and a compare.
// No clearing pass after reset; entries read before being written are undefined.
// A held result in the output register stalls only the next search's handover.
module key_table_search #(
    parameter int DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    kts_in_if.sink                      i_in,
    kts_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kts_pkg::PADDR_W-1:0] paddr,
    input  logic [kts_pkg::PDATA_W-1:0] pwdata,
    output logic [kts_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    kts_pkg::t_cfg             w_cfg;
    logic                      w_wr_en;
    logic [AW-1:0]             w_wr_addr;
    logic [kts_pkg::KEY_W-1:0] w_wr_data;
    logic [AW-1:0]             w_rd_addr;
    logic [kts_pkg::KEY_W-1:0] w_rd_data;

    kts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kts_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    kts_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

endmodule

@@ sim/kts_search_checker.sv @@
module kts_search_checker
    import kts_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    kts_in_if                  i_in,
    kts_out_if                 i_out,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic [PDATA_W-1:0] i_prdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_answer;

    // Own copy of the key store and the two registers
    logic signed [KEY_W-1:0] key_table [DEPTH];
    logic [MODE_W-1:0]       mode_reg;
    logic [CNT_W-1:0]        count_reg;

    // Answers owed for searches still inside the block, oldest first
    t_answer                 answer_q [$];
    t_answer                 want;
    logic [PDATA_W-1:0]      reg_value;

    task automatic note_mismatch(string what, int unsigned wanted, int unsigned actual);
        if (o_fail_count < 10) begin
            $display("MISMATCH at %0t: %s expected 0x%0h, got 0x%0h", $time, what, wanted, actual);
        end
        o_fail_count++;
    endtask

    // Look a key up the way the current mode and count say
    function automatic t_answer search_table(logic signed [KEY_W-1:0] k);
        t_answer a;
        int      n;
        int      lo;
        int      hi;
        int      mid;
        a  = '0;
        n  = (count_reg > DEPTH) ? DEPTH : int'(count_reg);
        if (mode_reg == MODE_BINARY) begin
            lo = 0;
            hi = n - 1;
            while (lo <= hi && !a.found) begin
                mid = (lo + hi) / 2;
                if (k < key_table[mid]) begin
                    hi = mid - 1;
                end else if (k > key_table[mid]) begin
                    lo = mid + 1;
                end else begin
                    a.found    = 1'b1;
                    a.position = POS_W'(mid);
                end
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                if (key_table[i] == k) begin
                    a.found    = 1'b1;
                    a.position = POS_W'(i);
                    break;
                end
                // ordered scan gives up once it passes the key
                if (mode_reg == MODE_ORDERED && k < key_table[i]) begin
                    break;
                end
            end
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_reg  = MODE_LINEAR;
            count_reg = '0;
            answer_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // Compare each returned result with the oldest search
            if (i_out.valid && i_out.ready) begin
                if (answer_q.size() == 0) begin
                    note_mismatch("result with no search waiting, position", 0,
                                  32'(i_out.position));
                end else begin
                    want = answer_q.pop_front();
                    if (i_out.found !== want.found) begin
                        note_mismatch("found", 32'(want.found), 32'(i_out.found));
                    end
                    if (i_out.position !== want.position) begin
                        note_mismatch("position", 32'(want.position), 32'(i_out.position));
                    end
                    o_checked++;
                end
            end
            // Store written keys, predict each search item
            if (i_in.valid && i_in.ready) begin
                if (i_in.action == ACT_WRITE) begin
                    key_table[i_in.entry_index] = i_in.key;
                end else begin
                    answer_q.push_back(search_table(i_in.key));
                end
            end
            // Follow register writes and check register reads
            if (i_psel && i_penable && i_pready) begin
                reg_value = (i_paddr[PADDR_W-1] == REG_MODE) ? PDATA_W'(mode_reg)
                                                             : PDATA_W'(count_reg);
                if (!i_pwrite) begin
                    if (i_prdata !== reg_value) begin
                        note_mismatch("register readback", reg_value, i_prdata);
                    end
                end else if (i_paddr[PADDR_W-1] == REG_MODE) begin
                    mode_reg = i_pwdata[MODE_W-1:0];
                end else begin
                    count_reg = i_pwdata[CNT_W-1:0];
                end
            end
        end
        o_pending = answer_q.size();
    end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    import kts_pkg::*;

    localparam int                      DEPTH        = 256;
    localparam int                      RANDOM_ITEMS = 220;
    localparam int                      STALL_LIMIT  = 4000;
    localparam int                      SETTLE       = 8;
    localparam logic [MODE_W-1:0]       MODE_UNUSED  = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN      = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX      = 32'sh7FFF_FFFF;
    localparam longint                  KEY_LO       = -64'sd2147483648;
    localparam longint                  KEY_HI       = 64'sd2147483647;

    logic               i_clk       = 1'b0;
    logic               i_rst_n;
    logic               recv_ready  = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int send_idle_pct  = 17;
    int recv_stall_pct = 56;
    int stall_cycles   = 0;
    int fail_count;
    int pending;
    int checked;
    int n_items;
    int n_writes;
    int n_searches;
    int n_settings;

    // Keys as last written, used to aim searches at present keys
    logic signed [KEY_W-1:0] shadow [DEPTH];

    kts_in_if  in_ch ();
    kts_out_if out_ch ();

    assign out_ch.ready = recv_ready;

    key_table_search #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    kts_search_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result channel at random
    always @(negedge i_clk) begin
        recv_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort when no handshake of any kind happens for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one item, idling first at random, and hold it until taken
    task automatic send_item(logic act, logic [IDX_W-1:0] idx, logic signed [KEY_W-1:0] k);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.entry_index <= idx;
        in_ch.key         <= k;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        if (act == ACT_WRITE) begin
            shadow[idx] = k;
            n_writes++;
        end else begin
            n_searches++;
        end
        n_items++;
    endtask

    // One register access: setup phase, then access phase
    task automatic apb_access(logic wr, logic sel, logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain the block, then write and read back both registers
    task automatic configure(logic [MODE_W-1:0] mode, logic [CNT_W-1:0] count);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
        apb_access(1'b1, REG_MODE, PDATA_W'(mode));
        apb_access(1'b0, REG_MODE, '0);
        apb_access(1'b1, REG_COUNT, PDATA_W'(count));
        apb_access(1'b0, REG_COUNT, '0);
        n_settings++;
    endtask

    // Fill every entry with ascending keys from the minimum to the maximum,
    // one duplicated pair included
    task automatic fill_spread();
        longint v;
        for (int i = 0; i < DEPTH; i++) begin
            v = KEY_LO + longint'(i) * 64'sd16777216 + longint'($urandom_range(24'hFF_FFFF));
            if (i == 0) begin
                v = KEY_LO;
            end else if (i == DEPTH - 1) begin
                v = KEY_HI;
            end else if (i == 40) begin
                v = longint'(shadow[39]);
            end
            send_item(ACT_WRITE, IDX_W'(i), KEY_W'(v));
        end
    endtask

    initial begin
        int                      base;
        int                      r;
        int                      j;
        int                      used;
        longint                  v;
        logic [MODE_W-1:0]       mode;
        logic [CNT_W-1:0]        count;
        logic signed [KEY_W-1:0] k;

        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_WRITE;
        in_ch.entry_index = '0;
        in_ch.key         = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        n_items           = 0;
        n_writes          = 0;
        n_searches        = 0;
        n_settings        = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table after reset: nothing can be found
        send_item(ACT_SEARCH, '0, '0);
        send_item(ACT_SEARCH, '1, KEY_MIN);
        configure(MODE_BINARY, '0);
        send_item(ACT_SEARCH, '0, KEY_MAX);

        // Whole table sorted, extremes at both ends
        fill_spread();
        configure(MODE_LINEAR, CNT_W'(DEPTH));
        send_item(ACT_SEARCH, '0, KEY_MIN);
        send_item(ACT_SEARCH, '0, KEY_MAX);
        send_item(ACT_SEARCH, '0, shadow[40]);
        send_item(ACT_SEARCH, '0, shadow[10] + 32'sd1);
        configure(MODE_ORDERED, CNT_W'(DEPTH));
        send_item(ACT_SEARCH, '0, KEY_MAX);
        send_item(ACT_SEARCH, '0, shadow[100] + 32'sd1);
        send_item(ACT_SEARCH, '0, shadow[39]);
        configure(MODE_BINARY, CNT_W'(DEPTH));
        send_item(ACT_SEARCH, '0, KEY_MIN);
        send_item(ACT_SEARCH, '0, KEY_MAX);
        send_item(ACT_SEARCH, '0, shadow[127]);
        send_item(ACT_SEARCH, '0, shadow[200] + 32'sd1);

        // Unused mode with a count beyond the depth
        configure(MODE_UNUSED, '1);
        send_item(ACT_SEARCH, '0, KEY_MAX);
        send_item(ACT_SEARCH, '0, shadow[50] + 32'sd1);

        // Single entry in use
        configure(MODE_BINARY, CNT_W'(1));
        send_item(ACT_SEARCH, '0, shadow[0]);
        send_item(ACT_SEARCH, '0, shadow[1]);

        // Break the ordering and let binary search run over it
        send_item(ACT_WRITE, IDX_W'(128), KEY_MIN);
        configure(MODE_BINARY, CNT_W'(DEPTH));
        send_item(ACT_SEARCH, '0, KEY_MIN);
        send_item(ACT_SEARCH, '0, shadow[129]);

        // Random phases: load a sorted prefix, then search it
        base = n_items;
        while (n_items - base < RANDOM_ITEMS) begin
            if (n_items - base < RANDOM_ITEMS / 3) begin
                send_idle_pct  = 17;
                recv_stall_pct = 56;
            end else if (n_items - base < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 56;
                recv_stall_pct = 17;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            // Mostly short tables; the full depth and beyond only now and then
            r = $urandom_range(99);
            if (r < 5) begin
                count = '0;
            end else if (r < 9) begin
                count = CNT_W'(DEPTH);
            end else if (r < 11) begin
                count = CNT_W'($urandom_range(511, DEPTH + 1));
            end else begin
                count = CNT_W'($urandom_range(32, 1));
            end
            mode = MODE_W'($urandom_range(MODE_UNUSED));
            used = (count > DEPTH) ? DEPTH : int'(count);
            configure(mode, count);

            if (used > 32) begin
                fill_spread();
            end else begin
                // Ascending keys from a random start, with runs of duplicates
                v = longint'(signed'($urandom));
                for (int i = 0; i < used; i++) begin
                    send_item(ACT_WRITE, IDX_W'(i), KEY_W'(v));
                    r = $urandom_range(99);
                    if (r >= 60) begin
                        v = v + longint'($urandom_range(32'h1000_0000, 1));
                    end else if (r >= 20) begin
                        v = v + longint'($urandom_range(16, 1));
                    end
                    if (v > KEY_HI) begin
                        v = KEY_HI;
                    end
                end
            end

            repeat ($urandom_range(16, 6)) begin
                // Stray writes may land inside the used entries and spoil the order
                if ($urandom_range(9) == 0) begin
                    send_item(ACT_WRITE, IDX_W'($urandom), $urandom);
                end
                r = $urandom_range(99);
                j = (used > 0) ? $urandom_range(used - 1) : 0;
                if (used == 0 || r >= 85) begin
                    k = $urandom;
                end else if (r < 60) begin
                    k = shadow[j];
                end else if (r < 75) begin
                    k = shadow[j] + ($urandom_range(1) ? 32'sd1 : -32'sd1);
                end else begin
                    k = $urandom_range(1) ? KEY_MIN : KEY_MAX;
                end
                send_item(ACT_SEARCH, IDX_W'($urandom), k);
            end
        end

        // Drain and let the last write settle
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);

        $display("Ran %0d items: %0d key writes and %0d searches over %0d register settings.",
                 n_items, n_writes, n_searches, n_settings);
        $display("Compared %0d search results, all four modes, counts from zero past the depth.",
                 checked);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
